[rtl/core/cr_pkg.sv]
`default_nettype none

package cr_pkg;

    // Table geometry and number formats.
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int COUNT_W    = 7;
    localparam int FRAC_BITS  = 16;
    localparam int T_W        = FRAC_BITS + 1;
    localparam int COORD_W    = 32;
    localparam int ENTRY_W    = 3 * COORD_W;

    // Horner accumulator width: the cubic coefficients of 32-bit points stay
    // well inside 40 bits at every step.
    localparam int H_W    = 40;
    localparam int PROD_W = H_W + T_W;

    // Input beat layout, lowest bit first: point_index, x, y, z, path_position.
    localparam int OFF_X      = ADDR_W;
    localparam int OFF_Y      = OFF_X + COORD_W;
    localparam int OFF_Z      = OFF_Y + COORD_W;
    localparam int OFF_T      = OFF_Z + COORD_W;
    localparam int IN_USED_W  = OFF_T + T_W;
    localparam int S_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ENTRY_W;

    // Item kinds carried on s_tuser.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [H_W-1:0]     wide_t;

    // Control from the sequencer to the axis lanes.
    typedef struct packed {
        logic                 start;
        logic [FRAC_BITS-1:0] frac;
    } cr_ctl_t;

    // Clamp a wide signed value to the signed coordinate range.
    function automatic coord_t sat_coord(input wide_t v);
        logic [H_W-COORD_W:0] upper;
        upper = v[H_W-1:COORD_W-1];
        if ((&upper) || !(|upper)) begin
            return v[COORD_W-1:0];
        end else if (v[H_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/cr_point_ram.sv]
`default_nettype none

// Single-port control point table with a registered read.
module cr_point_ram (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic                       we,
    input  wire logic [cr_pkg::ADDR_W-1:0]  addr,
    input  wire logic [cr_pkg::ENTRY_W-1:0] wdata,
    output logic      [cr_pkg::ENTRY_W-1:0] rdata
);
    import cr_pkg::*;

    logic [ENTRY_W-1:0] mem [MAX_POINTS];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/cr_axis_lane.sv]
`default_nettype none

// One axis of the cubic. Coefficients are formed at start, then the Horner
// form runs three multiply/add rounds, and the halved and clamped value is
// registered with a one-cycle done pulse.
module cr_axis_lane (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire cr_pkg::cr_ctl_t ctl,
    input  wire cr_pkg::coord_t  p0,
    input  wire cr_pkg::coord_t  p1,
    input  wire cr_pkg::coord_t  p2,
    input  wire cr_pkg::coord_t  p3,
    output logic                 done,
    output cr_pkg::coord_t       result
);
    import cr_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_ADD  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;
    localparam logic [1:0] LAST_STEP = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [1:0] step_reg, step_next;
    logic       done_reg;

    wide_t                     a_reg, b_reg, c_reg, h_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [FRAC_BITS-1:0]      u_reg;
    coord_t                    result_reg;

    wide_t e0, e1, e2, e3;
    wide_t coef_a, coef_b, coef_c, coef_d;
    wide_t addend, h_sum, h_inc, h_half;
    logic signed [PROD_W-1:0] prod_sh;

    assign e0 = H_W'(p0);
    assign e1 = H_W'(p1);
    assign e2 = H_W'(p2);
    assign e3 = H_W'(p3);

    assign coef_a = e1 <<< 1;
    assign coef_b = e2 - e0;
    assign coef_c = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    assign coef_d = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;

    always_comb begin
        case (step_reg)
            2'd0:    addend = c_reg;
            2'd1:    addend = b_reg;
            default: addend = a_reg;
        endcase
    end

    // Arithmetic shift of the signed product is the floor division.
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign h_sum   = H_W'(prod_sh) + addend;

    // Halving rounded half up.
    assign h_inc  = h_reg + H_W'(1);
    assign h_half = h_inc >>> 1;

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (ctl.start) begin
                    phase_next = PH_MUL;
                    step_next  = 2'd0;
                end
            end
            PH_MUL: begin
                phase_next = PH_ADD;
            end
            PH_ADD: begin
                if (step_reg == LAST_STEP) begin
                    phase_next = PH_FIN;
                end else begin
                    phase_next = PH_MUL;
                    step_next  = step_reg + 2'd1;
                end
            end
            PH_FIN: begin
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            step_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= (phase_reg == PH_FIN);
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == PH_IDLE && ctl.start) begin
            a_reg <= coef_a;
            b_reg <= coef_b;
            c_reg <= coef_c;
            h_reg <= coef_d;
            u_reg <= ctl.frac;
        end
        if (phase_reg == PH_MUL) begin
            prod_reg <= PROD_W'(h_reg) * PROD_W'($signed({1'b0, u_reg}));
        end
        if (phase_reg == PH_ADD) begin
            h_reg <= h_sum;
        end
        if (phase_reg == PH_FIN) begin
            result_reg <= sat_coord(h_half);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/core/catmull_rom_path_eval.sv]
`default_nettype none

// Uniform Catmull-Rom path evaluator over a table of up to 64 control points.
// Beats arrive on the s_ channel. A write beat (s_tuser low) stores x, y and z
// at point_index; it is dropped when the index is at or beyond point_count.
// An evaluate beat (s_tuser high) carries t in Q1.16 and produces one beat on
// the m_ channel with the interpolated x, y and z in Q16.16, saturated.
// point_count is loaded through cfg_wr_en / cfg_wr_data; the user must load
// it only while the block idles, as the block does not enforce this. Write
// beats stream at one beat per cycle while the block idles. An evaluate beat
// occupies the block until its result is registered: the four control points
// come out of the single-port table one per cycle, then each axis runs three
// multiply/add rounds of the Horner form. Only then is a new input beat taken.
// Results sit in an output register, so the next beat is accepted while the
// previous result still waits. If the receiver stalls and the register is
// still full when a new result is ready, the block holds that result and
// stops accepting input until the register frees up.
// Reset clears point_count and the control logic; table contents stay
// undefined until written.
module catmull_rom_path_eval (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cr_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // point_index[5:0], point_x[37:6], point_y[69:38], point_z[101:70],
    // path_position[118:102], zero pad [119]
    input  wire logic [cr_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  wire logic [0:0]                   s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic      [cr_pkg::M_TDATA_W-1:0] m_tdata
);
    import cr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_CALC  = 3'd5;
    localparam logic [2:0] S_HOLD  = 3'd6;

    localparam int PROG_W = FRAC_BITS + ADDR_W;
    localparam logic [1:0] LAST_READ = 2'd3;

    logic [2:0]           state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [1:0]           rd_cnt_reg;
    logic                 rd_vld_reg;
    logic [1:0]           rd_sel_reg;
    logic [T_W-1:0]       t_reg;
    logic [ADDR_W-1:0]    idx_reg [4];
    logic [FRAC_BITS-1:0] u_reg;
    logic                 zero_reg;
    logic [ENTRY_W-1:0]   pts_reg [4];
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Effective point count: register values above the table depth act as
    // the full table.
    logic [COUNT_W-1:0] n_eff;
    assign n_eff = (count_reg > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : count_reg;

    logic              s_accept;
    logic              in_kind;
    logic [ADDR_W-1:0] in_index;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_kind  = s_tuser[0];
    assign in_index = s_tdata[ADDR_W-1:0];

    // Segment selection. For t below one the segment is always below the
    // segment count, so no upper clamp is needed there.
    logic [ADDR_W-1:0]  segs, last_idx, seg;
    logic [PROG_W-1:0]  prog;
    logic [COUNT_W-1:0] seg_p2;
    logic [ADDR_W-1:0]  idx_calc [4];
    logic [FRAC_BITS-1:0] u_calc;

    assign segs     = ADDR_W'(n_eff - COUNT_W'(1));
    assign last_idx = segs;
    assign prog     = PROG_W'(t_reg[FRAC_BITS-1:0]) * PROG_W'(segs);
    assign seg      = prog[PROG_W-1:FRAC_BITS];
    assign seg_p2   = {1'b0, seg} + COUNT_W'(2);

    always_comb begin
        if (n_eff <= COUNT_W'(1)) begin
            // Empty or single-point table: every neighbor is the first entry.
            for (int k = 0; k < 4; k++) idx_calc[k] = '0;
            u_calc = '0;
        end else if (t_reg[FRAC_BITS]) begin
            // t at or beyond one: every neighbor is the last point.
            for (int k = 0; k < 4; k++) idx_calc[k] = last_idx;
            u_calc = '0;
        end else begin
            idx_calc[0] = (seg != '0) ? seg - ADDR_W'(1) : '0;
            idx_calc[1] = seg;
            idx_calc[2] = seg + ADDR_W'(1);
            idx_calc[3] = (seg_p2 < n_eff) ? seg_p2[ADDR_W-1:0] : last_idx;
            u_calc      = prog[FRAC_BITS-1:0];
        end
    end

    // Table port: writes are taken straight from the input beat in idle, reads
    // are issued from the neighbor list during the read phase.
    logic               ram_en, ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign ram_we   = (state_reg == S_IDLE);
    assign ram_en   = (state_reg == S_READ) ||
                      (s_accept && in_kind == KIND_WRITE && {1'b0, in_index} < n_eff);
    assign ram_addr = (state_reg == S_READ) ? idx_reg[rd_cnt_reg] : in_index;

    cr_point_ram u_table (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata[OFF_T-1:OFF_X]),
        .rdata (ram_rdata)
    );

    // Three axis lanes run in lockstep on the captured neighbor points.
    cr_ctl_t lane_ctl;
    logic [2:0] lane_done;
    coord_t     lane_res [3];

    assign lane_ctl.start = (state_reg == S_START);
    assign lane_ctl.frac  = u_reg;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        cr_axis_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .p0      (pts_reg[0][a*COORD_W +: COORD_W]),
            .p1      (pts_reg[1][a*COORD_W +: COORD_W]),
            .p2      (pts_reg[2][a*COORD_W +: COORD_W]),
            .p3      (pts_reg[3][a*COORD_W +: COORD_W]),
            .done    (lane_done[a]),
            .result  (lane_res[a])
        );
    end

    logic lane_done_all, out_free, out_load;
    assign lane_done_all = &lane_done;
    assign out_free      = !m_tvalid_reg || m_tready;
    assign out_load      = ((state_reg == S_CALC && lane_done_all) || state_reg == S_HOLD)
                           && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && in_kind == KIND_EVAL) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: state_next = S_READ;
            S_READ: begin
                if (rd_cnt_reg == LAST_READ) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:  state_next = S_START;
            S_START: state_next = S_CALC;
            S_CALC: begin
                if (lane_done_all) begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_cnt_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            rd_sel_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            rd_vld_reg <= (state_reg == S_READ);
            rd_sel_reg <= rd_cnt_reg;
            if (state_reg == S_READ) begin
                rd_cnt_reg <= rd_cnt_reg + 2'd1;
            end else begin
                rd_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            t_reg <= s_tdata[OFF_T +: T_W];
        end
        if (state_reg == S_SETUP) begin
            for (int k = 0; k < 4; k++) idx_reg[k] <= idx_calc[k];
            u_reg    <= u_calc;
            zero_reg <= (n_eff == '0);
        end
        if (rd_vld_reg) begin
            pts_reg[rd_sel_reg] <= ram_rdata;
        end
        if (out_load) begin
            m_tdata_reg <= zero_reg ? '0 : {lane_res[2], lane_res[1], lane_res[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // The lanes only finish while the sequencer waits for them.
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done_all |-> (state_reg == S_CALC))
        else $error("axis lanes finished outside the calculation phase");

    // Read data is captured only right after a read was issued.
    a_capture_window: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == S_READ || state_reg == S_WAIT))
        else $error("table read data captured outside the read phase");

    // Every neighbor read of a non-empty table stays inside the valid part of the table.
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && n_eff != '0) |-> ({1'b0, ram_addr} < n_eff))
        else $error("neighbor index beyond the point count");

    // A finished result never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HOLD && m_tvalid_reg && !m_tready) |=> (state_reg == S_HOLD))
        else $error("held result released while the output was full");
`endif

endmodule

`default_nettype wire

[sim/catmull_rom_checker.sv]
`timescale 1ns / 100ps

// Watches both beat channels and the point_count write port, keeps its own copy
// of the control point table and predicts every evaluated position.
module catmull_rom_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cr_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [cr_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]                   s_tuser,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [cr_pkg::M_TDATA_W-1:0] m_tdata,
    output int                                mismatch_count,
    output int                                pending_results,
    output int                                results_checked
);
    import cr_pkg::*;

    localparam int T_ONE          = 1 << FRAC_BITS;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    point_t             path_table [MAX_POINTS];
    logic [COUNT_W-1:0] active_count;
    point_t             expected_q [$];

    // One axis of the uniform cubic in Horner form, floored at every step.
    function automatic coord_t spline_axis(input longint p0, input longint p1,
                                           input longint p2, input longint p3,
                                           input longint u);
        longint a, b, c, d, h;
        a = 2 * p1;
        b = p2 - p0;
        c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d = -p0 + 3 * p1 - 3 * p2 + p3;
        h = ((d * u) >>> FRAC_BITS) + c;
        h = ((h * u) >>> FRAC_BITS) + b;
        h = ((h * u) >>> FRAC_BITS) + a;
        h = (h + 1) >>> 1;
        if (h > 64'sd2147483647) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        if (h < -64'sd2147483648) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return h[COORD_W-1:0];
    endfunction

    function automatic point_t predict_position(input logic [T_W-1:0] t);
        int     n, segs, prog, seg, i0, i3;
        longint u;
        point_t res;
        n = (active_count > MAX_POINTS) ? MAX_POINTS : int'(active_count);
        if (n == 0) begin
            return '0;
        end
        if (n == 1 || t == 0) begin
            return path_table[0];
        end
        if (t >= T_ONE) begin
            return path_table[n-1];
        end
        segs = n - 1;
        prog = int'(t) * segs;
        seg  = prog >> FRAC_BITS;
        u    = longint'(prog & (T_ONE - 1));
        if (seg >= segs) begin
            seg = segs - 1;
        end
        i0 = (seg > 0) ? seg - 1 : 0;
        i3 = (seg + 2 < n) ? seg + 2 : n - 1;
        res.x = spline_axis(path_table[i0].x, path_table[seg].x,
                            path_table[seg+1].x, path_table[i3].x, u);
        res.y = spline_axis(path_table[i0].y, path_table[seg].y,
                            path_table[seg+1].y, path_table[i3].y, u);
        res.z = spline_axis(path_table[i0].z, path_table[seg].z,
                            path_table[seg+1].z, path_table[i3].z, u);
        return res;
    endfunction

    task automatic log_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] checker: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin : monitor
        point_t             got, want;
        logic [ADDR_W-1:0]  idx;
        int                 n;
        if (!aresetn) begin
            active_count = '0;
        end else begin
            if (cfg_wr_en) begin
                active_count = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == KIND_WRITE) begin
                    idx = s_tdata[ADDR_W-1:0];
                    n   = (active_count > MAX_POINTS) ? MAX_POINTS : int'(active_count);
                    if (int'(idx) < n) begin
                        path_table[idx].x = s_tdata[OFF_X +: COORD_W];
                        path_table[idx].y = s_tdata[OFF_Y +: COORD_W];
                        path_table[idx].z = s_tdata[OFF_Z +: COORD_W];
                    end
                end else begin
                    want = predict_position(s_tdata[OFF_T +: T_W]);
                    expected_q.insert(expected_q.size(), want);
                end
            end
            if (m_tvalid && m_tready) begin
                got.x = m_tdata[COORD_W-1:0];
                got.y = m_tdata[2*COORD_W-1:COORD_W];
                got.z = m_tdata[3*COORD_W-1:2*COORD_W];
                results_checked++;
                if (expected_q.size() == 0) begin
                    log_error($sformatf("unexpected result beat (%0d, %0d, %0d)",
                                        got.x, got.y, got.z));
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        log_error($sformatf(
                            "position expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                            want.x, want.y, want.z, got.x, got.y, got.z));
                    end
                end
            end
        end
        pending_results = expected_q.size();
    end

endmodule

[sim/tb_catmull_rom_path_eval.sv]
`timescale 1ns / 100ps

module tb_catmull_rom_path_eval;
    import cr_pkg::*;

    // The long receiver hold-off used to back the block up into its input.
    localparam int RX_HOLD_CYCLES = 300;
    // Quiet cycles waited after the last result, so that the block is surely idle.
    localparam int SETTLE_CYCLES  = 24;
    // Cycles without any beat or register write before the run is abandoned.
    // The slowest correct stretch is the hold-off above plus one evaluation.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BEATS   = 64;
    localparam int NUM_PHASES     = 8;
    localparam int T_ONE          = 1 << FRAC_BITS;

    typedef logic [T_W-1:0] position_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [0:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int pending_results;
    int results_checked;

    // Idling controls, changed by the stimulus between phases.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // Flipped by the stimulus to ask the receiver for one long hold-off.
    bit hold_toggle  = 1'b0;

    int path_points = 0;
    int beats_sent  = 0;
    int evals_sent  = 0;
    int idle_cycles = 0;

    catmull_rom_path_eval dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    catmull_rom_checker path_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver side. It stalls at random according to rx_stall_pct and, when
    // asked, holds m_tready low for a long stretch that it counts itself.
    initial begin : rx_side
        bit hold_ack;
        int hold_left;
        hold_ack  = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_toggle != hold_ack) begin
                hold_ack  = hold_toggle;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: any beat on either channel or a register write counts as
    // progress. A long silence means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, pending_results);
            $display("tb_catmull_rom_path_eval: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly moderate coordinates so the cubic stays in range, with full-range
    // values and the two extremes mixed in to exercise saturation.
    function automatic coord_t pick_coord();
        case ($urandom_range(9))
            0:       return {1'b0, {(COORD_W-1){1'b1}}};
            1:       return {1'b1, {(COORD_W-1){1'b0}}};
            2, 3:    return coord_t'($urandom);
            default: return coord_t'($urandom) >>> 11;
        endcase
    endfunction

    // Path positions: mostly inside (0, 1), with the ends and values past 1.0
    // that still fit the 17-bit field.
    function automatic position_t pick_position();
        case ($urandom_range(19))
            0:       return '0;
            1:       return position_t'(T_ONE);
            2:       return position_t'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
            3:       return position_t'(T_ONE - 1);
            default: return position_t'($urandom_range(1, T_ONE - 1));
        endcase
    endfunction

    // Offers one beat, after a random gap, and returns right after the clock
    // edge at which it was taken. s_tvalid stays high for a following beat.
    task automatic send_beat(input logic kind, input logic [ADDR_W-1:0] idx,
                             input coord_t x, input coord_t y, input coord_t z,
                             input position_t t);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-IN_USED_W){1'b0}}, t, z, y, x, idx};
        do @(posedge aclk); while (s_tready !== 1'b1);
        beats_sent++;
    endtask

    // Unused fields carry random content so that every bit of them toggles.
    task automatic write_point(input int idx, input coord_t x, input coord_t y,
                               input coord_t z);
        send_beat(KIND_WRITE, ADDR_W'(idx), x, y, z, position_t'($urandom));
    endtask

    task automatic evaluate(input position_t t);
        send_beat(KIND_EVAL, ADDR_W'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), t);
        evals_sent++;
    endtask

    // Stops offering beats until every predicted position has come back, then
    // waits out the block's own pipeline.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_point_count(input int n);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(n);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        path_points = n;
    endtask

    // Every entry below the count gets written before any evaluation, so the
    // block never uses a table entry that was never written.
    task automatic fill_path();
        for (int i = 0; i < path_points; i++) begin
            write_point(i, pick_coord(), pick_coord(), pick_coord());
        end
    endtask

    task automatic random_beat();
        int idx;
        if ($urandom_range(99) < 40) begin
            if (path_points > 0 && $urandom_range(99) < 80) begin
                idx = $urandom_range(path_points - 1);
            end else begin
                // Often at or beyond the count, so the write should be dropped.
                idx = $urandom_range(MAX_POINTS - 1);
            end
            write_point(idx, pick_coord(), pick_coord(), pick_coord());
        end else begin
            evaluate(pick_position());
        end
    endtask

    initial begin : stimulus
        coord_t hi, lo;
        int     phase_counts [NUM_PHASES];
        hi = {1'b0, {(COORD_W-1){1'b1}}};
        lo = {1'b1, {(COORD_W-1){1'b0}}};
        phase_counts = '{2, 64, 3, 1, 9, 0, 2, 4};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: every evaluation gives the origin, and a write is
        // dropped because no entry is valid yet.
        evaluate('0);
        evaluate(position_t'(T_ONE));
        write_point(0, hi, lo, hi);
        evaluate(position_t'(T_ONE / 2));

        // A single point: every position gives that point.
        set_point_count(1);
        write_point(0, 32'sd65536, -32'sd131072, 32'sd7);
        evaluate(position_t'(40000));
        evaluate(position_t'((1 << T_W) - 1));

        // Five points of alternating extremes, so the cubic overshoots and
        // saturates in both directions.
        set_point_count(5);
        write_point(0, lo, hi, 0);
        write_point(1, hi, lo, 1);
        write_point(2, lo, hi, -1);
        write_point(3, hi, lo, 32'sd1000);
        write_point(4, lo, lo, hi);
        // With the count lowered to four, writes to entry 4 and to the top of
        // the table must both be dropped.
        set_point_count(4);
        write_point(4, hi, hi, lo);
        write_point(MAX_POINTS - 1, hi, hi, hi);
        evaluate('0);
        evaluate(position_t'(1));
        evaluate(position_t'(T_ONE / 2));
        evaluate(position_t'(T_ONE - 1));
        evaluate(position_t'(T_ONE));
        evaluate(position_t'((1 << T_W) - 1));
        // Entry 4 must still hold the point written while it was valid.
        set_point_count(5);
        evaluate(position_t'(T_ONE));

        // Random phases: each picks a point count and an idling pattern,
        // loads the table and then mixes writes with evaluations.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            set_point_count((p == 4) ? $urandom_range(5, MAX_POINTS - 1) : phase_counts[p]);
            fill_path();
            if (p == 0) begin
                // The receiver goes quiet while evaluations keep coming, so
                // the output register fills and s_tready has to drop.
                hold_toggle = ~hold_toggle;
                repeat (8) evaluate(pick_position());
            end
            for (int i = 0; i < RANDOM_BEATS; i++) begin
                if (p == 2 && i == RANDOM_BEATS / 2) begin
                    drain_results();
                end
                random_beat();
            end
        end

        drain_results();
        $display("Run covered %0d input beats, %0d of them evaluations, over point counts",
                 beats_sent, evals_sent);
        $display("from 0 to 64 with extreme coordinates; %0d result beats checked.",
                 results_checked);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb_catmull_rom_path_eval: PASS");
        end else begin
            $display("tb_catmull_rom_path_eval: FAIL");
        end
        $finish;
    end

endmodule
